// ===== rtl/core/lce_pkg.sv =====
// Shared types, codes and defaults for the linked list cursor engine.
`default_nettype none
package lce_pkg;

   localparam int DEF_POOL_DEPTH  = 256;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int MODE_W   = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT     = 4'd2;
   localparam logic [MODE_W-1:0] MODE_ERASE      = 4'd3;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd5;
   localparam logic [MODE_W-1:0] MODE_FRONT      = 4'd6;
   localparam logic [MODE_W-1:0] MODE_BACK       = 4'd7;
   localparam logic [MODE_W-1:0] MODE_NEXT       = 4'd8;
   localparam logic [MODE_W-1:0] MODE_PREV       = 4'd9;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_ELEM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_GET_FREE,
      ST_GET_CUR,
      ST_LINK_NODE,
      ST_LINK_NBR,
      ST_UNLINK_NBR,
      ST_UNLINK_FREE,
      ST_STEP,
      ST_READ_VAL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/linked_list_cursor_engine.sv =====
// Top level: doubly linked list with cursor, held in a node pool in memory.
`default_nettype none
// Ordered list engine over a pool of POOL_DEPTH nodes held in three synchronous
// memories (values, forward links, backward links), one read and one write port
// each. One item is worked at a time and every item returns one result. An item
// that is refused up front (no element, no cursor, full pool or an unknown mode)
// goes from the decide state straight to the result. A push or insert takes a
// freed slot (reading its forward link) or a never-used slot, insert then reads
// the cursor's follower, and the new node is written before its neighbor's link;
// erase and pop bypass the node and then chain it onto the free list. A stalled
// result channel adds its wait. The link memories have a registered read port,
// and the single forward-link write port serializes link updates.
// Freed nodes are chained through their forward links and reused first.
module linked_list_cursor_engine
   import lce_pkg::*;
#(
   parameter int POOL_DEPTH  = DEF_POOL_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(POOL_DEPTH);
   localparam int IW = AW + 1;
   localparam logic [IW-1:0] NIL = IW'(POOL_DEPTH);

   logic [VALUE_WIDTH-1:0] val_mem [POOL_DEPTH];
   logic [IW-1:0]          fwd_mem [POOL_DEPTH];
   logic [IW-1:0]          bwd_mem [POOL_DEPTH];

   state_type state_ff, state_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [IW-1:0]          head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [IW-1:0]          free_ff, free_in, fresh_ff, fresh_in, count_ff, count_in;
   logic [IW-1:0]          node_ff, node_in, nbr_ff, nbr_in;
   logic [STATUS_W-1:0]    st_ff, st_in;
   logic [VALUE_W-1:0]     rdv_ff, rdv_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic [VALUE_WIDTH-1:0] val_rd_ff;
   logic [IW-1:0]          fwd_rd_ff, bwd_rd_ff;

   logic [AW-1:0]          rd_addr;
   logic                   val_we, fwd_we, bwd_we;
   logic [AW-1:0]          val_wa, fwd_wa, bwd_wa;
   logic [VALUE_WIDTH-1:0] val_wd;
   logic [IW-1:0]          fwd_wd, bwd_wd;

   logic                   req_xfer, rsp_free;
   logic [IW-1:0]          pick_target, step_target;

   function automatic logic is_node(input logic [IW-1:0] idx);
      return idx < NIL;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // erase, pop back, pop front, front and back all act on one fixed node
   always_comb begin
      case (mode_ff)
         MODE_ERASE:                 pick_target = cur_ff;
         MODE_POP_BACK, MODE_BACK:   pick_target = tail_ff;
         MODE_POP_FRONT, MODE_FRONT: pick_target = head_ff;
         default:                    pick_target = NIL;
      endcase
   end

   assign step_target = (mode_ff == MODE_NEXT) ? fwd_rd_ff : bwd_rd_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            if (mode_ff inside {MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT}) begin
               if (mode_ff == MODE_INSERT && !is_node(cur_ff)) state_in = ST_RESP;
               else if (is_node(free_ff)) state_in = ST_GET_FREE;
               else if (fresh_ff < NIL)
                  state_in = (mode_ff == MODE_INSERT) ? ST_GET_CUR : ST_LINK_NODE;
            end else if (mode_ff inside {MODE_ERASE, MODE_POP_BACK, MODE_POP_FRONT}) begin
               if (is_node(pick_target)) state_in = ST_UNLINK_NBR;
            end else if (mode_ff inside {MODE_FRONT, MODE_BACK}) begin
               if (is_node(pick_target)) state_in = ST_READ_VAL;
            end else if (mode_ff inside {MODE_NEXT, MODE_PREV}) begin
               if (is_node(cur_ff)) state_in = ST_STEP;
            end
         end
         ST_GET_FREE:
            state_in = (mode_ff == MODE_INSERT) ? ST_GET_CUR : ST_LINK_NODE;
         ST_GET_CUR:     state_in = ST_LINK_NODE;
         ST_LINK_NODE:   state_in = ST_LINK_NBR;
         ST_LINK_NBR:    state_in = ST_RESP;
         ST_UNLINK_NBR:  state_in = ST_UNLINK_FREE;
         ST_UNLINK_FREE: state_in = ST_RESP;
         ST_STEP:        state_in = is_node(step_target) ? ST_READ_VAL : ST_RESP;
         ST_READ_VAL:    state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      mode_in  = mode_ff;
      value_in = value_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      cur_in   = cur_ff;
      free_in  = free_ff;
      fresh_in = fresh_ff;
      count_in = count_ff;
      node_in  = node_ff;
      nbr_in   = nbr_ff;
      st_in    = st_ff;
      rdv_in   = rdv_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr  = cur_ff[AW-1:0];
      val_we = 1'b0;
      fwd_we = 1'b0;
      bwd_we = 1'b0;
      val_wa = node_ff[AW-1:0];
      fwd_wa = node_ff[AW-1:0];
      bwd_wa = node_ff[AW-1:0];
      val_wd = VALUE_WIDTH'(value_ff);
      fwd_wd = NIL;
      bwd_wd = NIL;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in  = req_data.mode;
               value_in = req_data.value;
            end
         end
         ST_DECIDE: begin
            st_in  = STATUS_DONE;
            rdv_in = '0;
            if (mode_ff inside {MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT}) begin
               if (mode_ff == MODE_INSERT && !is_node(cur_ff)) begin
                  st_in = STATUS_NO_ELEM;
               end else if (is_node(free_ff)) begin
                  node_in = free_ff;
                  rd_addr = free_ff[AW-1:0];
               end else if (fresh_ff < NIL) begin
                  node_in  = fresh_ff;
                  fresh_in = fresh_ff + 1'b1;
               end else begin
                  st_in = STATUS_FULL;
               end
            end else if (mode_ff inside {MODE_ERASE, MODE_POP_BACK, MODE_POP_FRONT,
                                         MODE_FRONT, MODE_BACK}) begin
               node_in = pick_target;
               rd_addr = pick_target[AW-1:0];
               if (!is_node(pick_target)) st_in = STATUS_NO_ELEM;
            end else if (mode_ff inside {MODE_NEXT, MODE_PREV}) begin
               if (!is_node(cur_ff)) st_in = STATUS_NO_ELEM;
            end else begin
               st_in = STATUS_NO_ELEM;
            end
         end
         ST_GET_FREE: begin
            free_in = fwd_rd_ff;
         end
         ST_GET_CUR: begin
            nbr_in = fwd_rd_ff;
         end
         ST_LINK_NODE: begin
            val_we = 1'b1;
            fwd_we = 1'b1;
            bwd_we = 1'b1;
            case (mode_ff)
               MODE_PUSH_BACK: begin
                  fwd_wd = NIL;
                  bwd_wd = tail_ff;
               end
               MODE_PUSH_FRONT: begin
                  fwd_wd = head_ff;
                  bwd_wd = NIL;
               end
               default: begin
                  fwd_wd = nbr_ff;
                  bwd_wd = cur_ff;
               end
            endcase
         end
         ST_LINK_NBR: begin
            count_in = count_ff + 1'b1;
            fwd_wd   = node_ff;
            bwd_wd   = node_ff;
            case (mode_ff)
               MODE_PUSH_BACK: begin
                  fwd_we = is_node(tail_ff);
                  fwd_wa = tail_ff[AW-1:0];
                  if (!is_node(tail_ff)) head_in = node_ff;
                  tail_in = node_ff;
               end
               MODE_PUSH_FRONT: begin
                  bwd_we = is_node(head_ff);
                  bwd_wa = head_ff[AW-1:0];
                  if (!is_node(head_ff)) tail_in = node_ff;
                  head_in = node_ff;
               end
               default: begin
                  bwd_we = is_node(nbr_ff);
                  bwd_wa = nbr_ff[AW-1:0];
                  if (!is_node(nbr_ff)) tail_in = node_ff;
                  fwd_we = 1'b1;
                  fwd_wa = cur_ff[AW-1:0];
               end
            endcase
         end
         ST_UNLINK_NBR: begin
            // bypass the node: its predecessor and follower point at each other
            fwd_we = is_node(bwd_rd_ff);
            fwd_wa = bwd_rd_ff[AW-1:0];
            fwd_wd = fwd_rd_ff;
            bwd_we = is_node(fwd_rd_ff);
            bwd_wa = fwd_rd_ff[AW-1:0];
            bwd_wd = bwd_rd_ff;
            if (!is_node(bwd_rd_ff)) head_in = fwd_rd_ff;
            if (!is_node(fwd_rd_ff)) tail_in = bwd_rd_ff;
            cur_in = fwd_rd_ff;
         end
         ST_UNLINK_FREE: begin
            fwd_we  = 1'b1;
            fwd_wd  = free_ff;
            free_in = node_ff;
            if (count_ff != '0) count_in = count_ff - 1'b1;
         end
         ST_STEP: begin
            node_in = step_target;
            rd_addr = step_target[AW-1:0];
            if (!is_node(step_target)) st_in = STATUS_NO_ELEM;
         end
         ST_READ_VAL: begin
            cur_in = node_ff;
            rdv_in = VALUE_W'(val_rd_ff);
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = st_ff;
               rsp_in.read_value  = rdv_ff;
               rsp_in.entry_count = COUNT_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         cur_ff       <= NIL;
         free_ff      <= NIL;
         fresh_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cur_ff       <= cur_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      value_ff <= value_in;
      node_ff  <= node_in;
      nbr_ff   <= nbr_in;
      st_ff    <= st_in;
      rdv_ff   <= rdv_in;
      rsp_ff   <= rsp_in;
   end

   // node pool memories
   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_wa] <= val_wd;
      val_rd_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
      fwd_rd_ff <= fwd_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
      bwd_rd_ff <= bwd_mem[rd_addr];
   end

endmodule
`default_nettype wire
